### rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table search/insert unit.
// ----------------------------------------------------------------------------
package skt_pkg;

  // request actions
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } skt_status_t;

  // request payload
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
  } skt_in_t;

  // result payload
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] position;
    logic [8:0] entries;
  } skt_out_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } skt_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } skt_cmd_t;

endpackage

### rtl/core/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: takes one request, executes it once the output register is free, holds the result.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output skt_pkg::skt_cmd_t cmd
);
  import skt_pkg::*;

  skt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       exec_ok;

  // execute only once the output register is free or being emptied
  assign exec_ok = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = exec_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_ok) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/skt_dp.sv
// ----------------------------------------------------------------------------
// skt_dp
// Datapath: a row of key cells that compare in parallel and shift up on insert,
// the entry count and the result register.
// ----------------------------------------------------------------------------
module skt_dp #(
  parameter int DEPTH     = 256,
  parameter int KEY_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  skt_pkg::skt_cmd_t cmd,
  input  skt_pkg::skt_in_t  in_data,
  output skt_pkg::skt_out_t out_data
);
  import skt_pkg::*;

  localparam int KW = (KEY_BYTES * 8 < 32) ? KEY_BYTES * 8 : 32;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [KW-1:0]  key_r;
  logic [1:0]     act_r;
  logic [KW-1:0]  cell_r [DEPTH];
  logic [CW-1:0]  count_r, count_nxt;
  skt_out_t       res_r, res_nxt;

  logic [DEPTH-1:0] lt, eq, lt_prev, hit_eq, slot;
  logic             found, full, do_insert;
  logic [IW-1:0]    found_pos, slot_pos, pos;
  logic [IW+7:0]    pos_ext;
  logic [CW+8:0]    cnt_ext;

  // request capture, key masked to its width
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r <= in_data.key[KW-1:0];
      act_r <= in_data.action;
    end
  end

  // per-cell compare against the needle; cells at or above count are empty
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    localparam logic [CW-1:0] IDX = CW'(i);
    logic in_use;
    assign in_use = IDX < count_r;
    assign lt[i]  = in_use && (cell_r[i] < key_r);
    assign eq[i]  = in_use && (cell_r[i] == key_r);
  end

  // lower bound is the first cell that is not below the needle
  assign lt_prev = {lt[DEPTH-2:0], 1'b1};
  assign hit_eq  = eq & lt_prev;
  assign slot    = ~lt & lt_prev;

  assign found     = |hit_eq;
  assign full      = (count_r == FULL_COUNT);
  assign do_insert = cmd.exec && (act_r == ACT_INSERT) && !found && !full;

  // one-hot to index encoders
  always_comb begin
    found_pos = '0;
    slot_pos  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_eq[i]) found_pos = found_pos | IW'(i);
      if (slot[i])   slot_pos  = slot_pos | IW'(i);
    end
  end

  // cell row: cells at and above the slot shift up, the slot takes the key
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_insert && !lt[0]) cell_r[0] <= key_r;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (do_insert && !lt[i]) begin
          cell_r[i] <= lt_prev[i] ? key_r : cell_r[i-1];
        end
      end
    end
  end

  // result and next count
  always_comb begin
    count_nxt = count_r;
    pos       = '0;
    res_nxt   = '0;
    if (act_r == ACT_CLEAR) begin
      count_nxt      = '0;
      res_nxt.status = ST_CLEARED;
    end else if (found) begin
      pos            = found_pos;
      res_nxt.status = ST_FOUND;
    end else if (act_r != ACT_INSERT) begin
      res_nxt.status = ST_NOT_FOUND;
    end else if (full) begin
      res_nxt.status = ST_FULL;
    end else begin
      count_nxt      = count_r + CW'(1);
      pos            = slot_pos;
      res_nxt.status = ST_INSERTED;
    end
    pos_ext          = {8'd0, pos};
    cnt_ext          = {9'd0, count_nxt};
    res_nxt.position = pos_ext[7:0];
    res_nxt.entries  = cnt_ext[8:0];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) res_r <= res_nxt;
  end

  assign out_data = res_r;

endmodule

### rtl/core/sorted_key_table_search_insert_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_unit
// Ascending key table with lookup, lookup-with-insert and clear.
// ----------------------------------------------------------------------------
// A request on in_* (valid/ready) carries an action and a key. Every request
// produces one result on out_*: status, position and the entry count after
// the request. Keys compare as unsigned values of KEY_BYTES bytes, at most 4.
// Each request is accepted in S_IDLE and then executed in S_EXEC, in which
// all DEPTH cells compare against the key in parallel and, on insert,
// shift up by one. The result is valid in the cycle after the execute cycle,
// and the next request can be accepted in that same cycle. A new request is
// not taken until the current one has executed.
// A result waits in the output register while out_ready is low; a request
// accepted meanwhile holds in its execute cycle until the register frees.
// Reset empties the table (entry count zero) and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert_unit #(
  parameter int DEPTH     = 256,
  parameter int KEY_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  skt_pkg::skt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output skt_pkg::skt_out_t out_data
);
  import skt_pkg::*;

  skt_cmd_t cmd;

  // sequencer
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // key cells, count and result register
  skt_dp #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
